@@ rtl/glpcm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and arithmetic helpers for the gamma PWM compare mapper.
// No dependencies; used by every other file in rtl/.

package glpcm_pkg;

	localparam int unsigned TABLE_STEPS_DEF = 4096;
	localparam int unsigned NUM_STAGES      = 9;
	localparam int unsigned PADDR_W         = 4;

	localparam logic [15:0] Q16_FULL     = 16'hFFFF;
	localparam logic [15:0] Q16_HALF     = 16'd32767;
	localparam logic [9:0]  PERMILLE_MAX = 10'd1000;

	// permille -> Q16: 65*p + (535*p + 500) / 1000, the divide by reciprocal
	localparam logic [15:0] PM_INT   = 16'd65;
	localparam logic [19:0] PM_FRAC  = 20'd535;
	localparam logic [19:0] PM_ROUND = 20'd500;
	localparam logic [20:0] PM_RECIP = 21'd1073742;
	localparam int unsigned PM_SHIFT = 30;

	localparam logic [15:0] PERIOD_RST = 16'd4199;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_LINEAR = 2'd1;
	localparam logic [1:0] REQ_RAW    = 2'd2;

	localparam logic [1:0] REG_TIMER_PERIOD   = 2'd0;
	localparam logic [1:0] REG_MIN_DUTY       = 2'd1;
	localparam logic [1:0] REG_ACTIVE_HIGH    = 2'd2;
	localparam logic [1:0] REG_OUTPUT_ENABLED = 2'd3;

	typedef struct packed {
		logic [15:0] timer_period;
		logic [15:0] min_nonzero_duty;
		logic        active_high;
		logic        output_enabled;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STAGES:1] en;
		logic [NUM_STAGES:1] vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic [15:0] compare;
		logic [15:0] duty;
		logic [9:0]  permille;
		logic        apply;
	} res_t;

	// floor(x / 65535): x = a*65535 + (a + b) with a = x[31:16], b = x[15:0]
	function automatic logic [16:0] div_q16_full(input logic [31:0] x);
		logic [16:0] t;
		logic [16:0] q;
		t = {1'b0, x[31:16]} + {1'b0, x[15:0]};
		q = {1'b0, x[31:16]};
		if (t >= 17'd131070) begin
			q = q + 17'd2;
		end else if (t >= 17'd65535) begin
			q = q + 17'd1;
		end
		return q;
	endfunction

	function automatic logic [15:0] raise_min(input logic [16:0] d, input logic [15:0] m);
		logic [16:0] r;
		r = d;
		if (d != 17'd0 && d < {1'b0, m}) begin
			r = {1'b0, m};
		end
		if (r > {1'b0, Q16_FULL}) begin
			r = {1'b0, Q16_FULL};
		end
		return r[15:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/gamma_lut_pwm_compare_mapper.sv @@
// An accepted request beat passes every pipeline stage and then the result register before res_valid shows it.
// Throughput: one beat per cycle; stalls collapse bubbles stage by stage.
// The table RAM is read (two ports) and written by the same stage, in order.
// Reset: pipeline empty, compare/duty/permille zero, registers at defaults.
// Gamma table contents are undefined after reset until loaded.
`timescale 1ns / 1ps
`default_nettype none

module gamma_lut_pwm_compare_mapper #(
	parameter int unsigned TABLE_STEPS = glpcm_pkg::TABLE_STEPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [glpcm_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [1:0]                    req_type,
	input  wire logic [15:0]                   level,
	input  wire logic                          in_permille,
	input  wire logic [12:0]                   table_index,
	input  wire logic [15:0]                   table_value,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic      [15:0]                   compare_count,
	output logic      [15:0]                   duty_q16,
	output logic      [9:0]                    duty_permille,
	output logic                               applied
);
	import glpcm_pkg::*;

	cfg_t      cfg;
	pipe_ctl_t ctl;
	res_t      res;

	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES:1]   vld_in;
	logic [NUM_STAGES+1:1] en;
	logic                  res_valid_q;
	logic [15:0]           cur_compare_q;
	logic [15:0]           cur_duty_q;
	logic [9:0]            cur_permille_q;
	logic                  applied_q;
	logic                  commit;

	glpcm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	always_comb begin
		en[NUM_STAGES+1] = !res_valid_q || res_ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in    = {vld_q[NUM_STAGES-1:1], req_valid};
	assign ctl.en    = en[NUM_STAGES:1];
	assign ctl.vld   = vld_q;
	assign req_ready = en[1];
	assign commit    = en[NUM_STAGES+1] && vld_q[NUM_STAGES] && res.apply;

	glpcm_datapath #(
		.TABLE_STEPS(TABLE_STEPS)
	) u_datapath (
		.clk        (clk),
		.ctl        (ctl),
		.cfg        (cfg),
		.req_type   (req_type),
		.level      (level),
		.in_permille(in_permille),
		.table_index(table_index),
		.table_value(table_value),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q          <= '0;
			res_valid_q    <= 1'b0;
			cur_compare_q  <= 16'd0;
			cur_duty_q     <= 16'd0;
			cur_permille_q <= 10'd0;
			applied_q      <= 1'b0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
			if (en[NUM_STAGES+1]) begin
				res_valid_q <= vld_q[NUM_STAGES];
				if (vld_q[NUM_STAGES]) begin
					applied_q <= res.apply;
				end
			end
			if (commit) begin
				cur_compare_q  <= res.compare;
				cur_duty_q     <= res.duty;
				cur_permille_q <= res.permille;
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign compare_count = cur_compare_q;
	assign duty_q16      = cur_duty_q;
	assign duty_permille = cur_permille_q;
	assign applied       = applied_q;

	a_permille_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_permille_q <= PERMILLE_MAX)
		else $error("permille out of range");

	a_zero_duty_zero_permille: assert property (@(posedge clk) disable iff (!arst_n)
		cur_duty_q == 16'd0 |-> cur_permille_q == 10'd0)
		else $error("zero duty with nonzero permille");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(cur_compare_q) && $stable(cur_duty_q))
		else $error("compare or duty changed without an applied beat");

endmodule

`default_nettype wire

@@ rtl/glpcm_table_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Gamma table storage: one write port, two registered read ports.
// Depends on glpcm_pkg for the default depth.

module glpcm_table_ram #(
	parameter int unsigned DEPTH = glpcm_pkg::TABLE_STEPS_DEF + 1,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [15:0]   wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr0,
	input  wire logic [AW-1:0] rd_addr1,
	output logic      [15:0]   rd_data0,
	output logic      [15:0]   rd_data1
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data0 <= mem[rd_addr0];
			rd_data1 <= mem[rd_addr1];
		end
	end

endmodule

`default_nettype wire

@@ rtl/glpcm_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// APB register file: timer period, minimum duty, polarity, output enable.
// Depends on glpcm_pkg.

module glpcm_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [glpcm_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output glpcm_pkg::cfg_t                    cfg
);
	import glpcm_pkg::*;

	cfg_t cfg_q;
	logic wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_period     <= PERIOD_RST;
			cfg_q.min_nonzero_duty <= 16'd0;
			cfg_q.active_high      <= 1'b1;
			cfg_q.output_enabled   <= 1'b0;
		end else if (wr_hit) begin
			case (paddr[3:2])
				REG_TIMER_PERIOD:   cfg_q.timer_period     <= pwdata[15:0];
				REG_MIN_DUTY:       cfg_q.min_nonzero_duty <= pwdata[15:0];
				REG_ACTIVE_HIGH:    cfg_q.active_high      <= pwdata[0];
				REG_OUTPUT_ENABLED: cfg_q.output_enabled   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TIMER_PERIOD:   prdata = {16'd0, cfg_q.timer_period};
			REG_MIN_DUTY:       prdata = {16'd0, cfg_q.min_nonzero_duty};
			REG_ACTIVE_HIGH:    prdata = {31'd0, cfg_q.active_high};
			REG_OUTPUT_ENABLED: prdata = {31'd0, cfg_q.output_enabled};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/glpcm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Nine-stage mapping pipeline: permille conversion, table index, table
// read/write, interpolation, minimum duty, compare scaling. Uses glpcm_table_ram.

module glpcm_datapath #(
	parameter int unsigned TABLE_STEPS = glpcm_pkg::TABLE_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire glpcm_pkg::pipe_ctl_t ctl,
	input  wire glpcm_pkg::cfg_t      cfg,
	input  wire logic [1:0]           req_type,
	input  wire logic [15:0]          level,
	input  wire logic                 in_permille,
	input  wire logic [12:0]          table_index,
	input  wire logic [15:0]          table_value,
	output glpcm_pkg::res_t           res
);
	import glpcm_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_STEPS + 1);
	localparam int unsigned SW = 16 + AW;
	localparam logic [SW-1:0] STEPS_W = SW'(TABLE_STEPS);
	localparam logic [12:0]   STEPS_IDX = 13'(TABLE_STEPS);

	// stage 1
	logic [1:0]  req_s1;
	logic [15:0] level_s1;
	logic        perm_s1;
	logic [12:0] tidx_s1;
	logic [15:0] tval_s1;
	logic [19:0] pnum_s1;
	logic [15:0] pbase_s1;
	logic [9:0]  pm_clamp;

	assign pm_clamp = (level > {6'd0, PERMILLE_MAX}) ? PERMILLE_MAX : level[9:0];

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			req_s1   <= req_type;
			level_s1 <= level;
			perm_s1  <= in_permille;
			tidx_s1  <= table_index;
			tval_s1  <= table_value;
			pnum_s1  <= {10'd0, pm_clamp} * PM_FRAC + PM_ROUND;
			pbase_s1 <= {6'd0, pm_clamp} * PM_INT;
		end
	end

	// stage 2
	logic [1:0]  req_s2;
	logic [15:0] level_s2;
	logic        perm_s2;
	logic [12:0] tidx_s2;
	logic [15:0] tval_s2;
	logic [15:0] pbase_s2;
	logic [9:0]  pfrac_s2;
	logic [40:0] pm_prod;

	assign pm_prod = {21'd0, pnum_s1} * {20'd0, PM_RECIP};

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			req_s2   <= req_s1;
			level_s2 <= level_s1;
			perm_s2  <= perm_s1;
			tidx_s2  <= tidx_s1;
			tval_s2  <= tval_s1;
			pbase_s2 <= pbase_s1;
			pfrac_s2 <= pm_prod[PM_SHIFT +: 10];
		end
	end

	// stage 3
	logic [1:0]  req_s3;
	logic [12:0] tidx_s3;
	logic [15:0] tval_s3;
	logic [15:0] q_s3;

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			req_s3  <= req_s2;
			tidx_s3 <= tidx_s2;
			tval_s3 <= tval_s2;
			q_s3    <= perm_s2 ? pbase_s2 + {6'd0, pfrac_s2} : level_s2;
		end
	end

	// stage 4: index and fraction, table access issue
	logic [1:0]    req_s4;
	logic [12:0]   tidx_s4;
	logic [15:0]   tval_s4;
	logic [15:0]   q_s4;
	logic          full_s4;
	logic [SW-1:0] s_s4;

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			req_s4  <= req_s3;
			tidx_s4 <= tidx_s3;
			tval_s4 <= tval_s3;
			q_s4    <= q_s3;
			full_s4 <= (q_s3 == Q16_FULL);
			s_s4    <= {AW'(0), q_s3} * STEPS_W;
		end
	end

	logic [AW-1:0] s_hi;
	logic [16:0]   s_sum;
	logic          s_carry;
	logic [AW-1:0] idx;
	logic [15:0]   frac;
	logic [AW-1:0] rd_addr0;
	logic [AW-1:0] rd_addr1;
	logic          wr_en;
	logic [15:0]   rd_data0;
	logic [15:0]   rd_data1;

	assign s_hi     = s_s4[SW-1:16];
	assign s_sum    = {1'b0, s_s4[15:0]} + 17'(s_hi);
	assign s_carry  = (s_sum >= 17'(Q16_FULL));
	assign idx      = s_hi + AW'(s_carry);
	assign frac     = s_carry ? 16'(s_sum - 17'(Q16_FULL)) : s_sum[15:0];
	assign rd_addr0 = full_s4 ? '0 : idx;
	assign rd_addr1 = full_s4 ? '0 : idx + AW'(1);

	// a load and a read never share a stage, so writes land before later reads
	assign wr_en = ctl.en[5] && ctl.vld[4] && (req_s4 == REQ_LOAD) && (tidx_s4 <= STEPS_IDX);

	glpcm_table_ram #(
		.DEPTH(TABLE_STEPS + 1)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tidx_s4[AW-1:0]),
		.wr_data (tval_s4),
		.rd_en   (ctl.en[5]),
		.rd_addr0(rd_addr0),
		.rd_addr1(rd_addr1),
		.rd_data0(rd_data0),
		.rd_data1(rd_data1)
	);

	// stage 5: table data arrives
	logic [1:0]  req_s5;
	logic [15:0] q_s5;
	logic        full_s5;
	logic [15:0] f_s5;

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			req_s5  <= req_s4;
			q_s5    <= q_s4;
			full_s5 <= full_s4;
			f_s5    <= frac;
		end
	end

	logic signed [16:0] tbl_diff;
	logic signed [33:0] tbl_prod;

	assign tbl_diff = $signed({1'b0, rd_data1}) - $signed({1'b0, rd_data0});
	assign tbl_prod = 34'(tbl_diff) * 34'($signed({1'b0, f_s5}));

	// stage 6
	logic [1:0]         req_s6;
	logic [15:0]        q_s6;
	logic               full_s6;
	logic [15:0]        base_s6;
	logic signed [33:0] prod_s6;

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			req_s6  <= req_s5;
			q_s6    <= q_s5;
			full_s6 <= full_s5;
			base_s6 <= rd_data0;
			prod_s6 <= tbl_prod;
		end
	end

	// T0*65535 + (T1-T0)*f + half, never negative
	logic signed [34:0] acc_w;

	assign acc_w = $signed({3'd0, base_s6, 16'd0}) - $signed({19'd0, base_s6})
		+ 35'(prod_s6) + $signed({19'd0, Q16_HALF});

	// stage 7
	logic [1:0]  req_s7;
	logic [15:0] q_s7;
	logic        full_s7;
	logic [31:0] acc_s7;

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			req_s7  <= req_s6;
			q_s7    <= q_s6;
			full_s7 <= full_s6;
			acc_s7  <= acc_w[31:0];
		end
	end

	logic [15:0] lin_duty;
	logic [15:0] raw_duty;
	logic [15:0] duty;

	assign lin_duty = full_s7 ? Q16_FULL
		: raise_min(div_q16_full(acc_s7), cfg.min_nonzero_duty);
	assign raw_duty = raise_min({1'b0, q_s7}, cfg.min_nonzero_duty);
	assign duty     = (req_s7 == REQ_LINEAR) ? lin_duty : raw_duty;

	// stage 8
	logic [1:0]  req_s8;
	logic [15:0] d_s8;

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			req_s8 <= req_s7;
			d_s8   <= duty;
		end
	end

	logic [31:0] cmp_x;
	logic [25:0] pm_x;

	assign cmp_x = {16'd0, d_s8} * {16'd0, cfg.timer_period} + {16'd0, Q16_HALF};
	assign pm_x  = {10'd0, d_s8} * {16'd0, PERMILLE_MAX} + {10'd0, Q16_HALF};

	// stage 9
	logic [1:0]  req_s9;
	logic [15:0] d_s9;
	logic [31:0] cmpx_s9;
	logic [25:0] pmx_s9;

	always_ff @(posedge clk) begin
		if (ctl.en[9]) begin
			req_s9  <= req_s8;
			d_s9    <= d_s8;
			cmpx_s9 <= cmp_x;
			pmx_s9  <= pm_x;
		end
	end

	logic [16:0] cmp_q;
	logic [15:0] cmp_clamp;
	logic [16:0] pm_q;

	assign cmp_q     = div_q16_full(cmpx_s9);
	assign cmp_clamp = (cmp_q > {1'b0, cfg.timer_period}) ? cfg.timer_period : cmp_q[15:0];
	assign pm_q      = div_q16_full({6'd0, pmx_s9});

	assign res.compare  = cfg.active_high ? cmp_clamp : cfg.timer_period - cmp_clamp;
	assign res.duty     = d_s9;
	assign res.permille = pm_q[9:0];
	assign res.apply    = cfg.output_enabled && (req_s9 == REQ_LINEAR || req_s9 == REQ_RAW);

endmodule

`default_nettype wire
